FILE: src/ssnr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnr_pkg
// Shared types, constants and the segment table of the number renderer.
// ----------------------------------------------------------------------------
package ssnr_pkg;

  localparam int unsigned NumDigits = 3;
  localparam int unsigned MaxValue  = 10 ** NumDigits - 1;
  localparam int unsigned ValW      = $clog2(MaxValue + 1);
  localparam int unsigned DigIdxW   = (NumDigits > 1) ? $clog2(NumDigits) : 1;
  localparam int unsigned CntW      = $clog2(NumDigits + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);
  localparam logic [15:0] DivTenMul = 16'hCCCD;
  localparam int unsigned DivTenShift = 19;
  localparam int unsigned NumSegs   = 7;

  localparam logic [2:0] SegTop   = 3'd0;
  localparam logic [2:0] SegUpL   = 3'd1;
  localparam logic [2:0] SegUpR   = 3'd2;
  localparam logic [2:0] SegMid   = 3'd3;
  localparam logic [2:0] SegLowL  = 3'd4;
  localparam logic [2:0] SegLowR  = 3'd5;
  localparam logic [2:0] SegBot   = 3'd6;

  typedef enum logic [2:0] {
    CfgScreenWidth = 3'd0,
    CfgDigitWidth  = 3'd1,
    CfgDigitHeight = 3'd2,
    CfgThickness   = 3'd3,
    CfgSpacing     = 3'd4,
    CfgBandTop     = 3'd5,
    CfgBgColor     = 3'd6,
    CfgDigitColor  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [7:0]  digit_width;
    logic [7:0]  digit_height;
    logic [5:0]  segment_thickness;
    logic [7:0]  digit_spacing;
    logic [11:0] band_top;
    logic [15:0] background_color;
    logic [15:0] digit_color;
  } cfg_t;

  typedef struct packed {
    logic [NumDigits-1:0][3:0] digits;
    logic [CntW-1:0]           ndig;
    logic [15:0]               x_start;
  } job_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] color;
    logic        last;
  } rect_t;

  typedef enum logic [1:0] {
    FrontIdle,
    FrontDiv,
    FrontPush
  } front_state_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackClear,
    BackDigit
  } back_state_e;

  function automatic logic [NumSegs-1:0] seg_of(input logic [3:0] d);
    logic [NumSegs-1:0] s;
    case (d)
      4'd0:    s = 7'h77;
      4'd1:    s = 7'h24;
      4'd2:    s = 7'h5D;
      4'd3:    s = 7'h6D;
      4'd4:    s = 7'h2E;
      4'd5:    s = 7'h6B;
      4'd6:    s = 7'h7B;
      4'd7:    s = 7'h25;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: src/ssnr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnr_front
// Accepts values, clamps and filters repeats, splits into decimal digits and
// queues a render job with digit count and group start x.
// ----------------------------------------------------------------------------
module ssnr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssnr_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [15:0]   in_value_i,
  output logic               push_o,
  input  wire logic          push_ready_i,
  output ssnr_pkg::job_t     job_o
);

  ssnr_pkg::front_state_e state_q, state_d;
  logic [15:0] shown_q, shown_d;
  logic [ssnr_pkg::ValW-1:0] rem_q, rem_d;
  logic [ssnr_pkg::NumDigits-1:0][3:0] digits_q, digits_d;
  logic [ssnr_pkg::DigIdxW-1:0] cnt_q, cnt_d;

  logic [15:0] clamped;
  logic [ssnr_pkg::ValW+15:0] prod;
  logic [ssnr_pkg::ValW-1:0] quot;
  logic [ssnr_pkg::ValW-1:0] quot_x10;
  logic [ssnr_pkg::ValW-1:0] digit_full;
  logic [ssnr_pkg::CntW-1:0] ndig;
  logic [15:0] n16;
  logic [15:0] total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssnr_pkg::FrontIdle;
      shown_q <= 16'hFFFF;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      shown_q <= shown_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    digits_q <= digits_d;
  end

  assign clamped = (in_value_i > 16'(ssnr_pkg::MaxValue)) ?
                   16'(ssnr_pkg::MaxValue) : in_value_i;

  assign prod     = {16'b0, rem_q} * {{ssnr_pkg::ValW{1'b0}}, ssnr_pkg::DivTenMul};
  assign quot     = ssnr_pkg::ValW'(prod[ssnr_pkg::ValW+15:ssnr_pkg::DivTenShift]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit_full = rem_q - quot_x10;

  always_comb begin
    logic found;
    found = 1'b0;
    ndig  = ssnr_pkg::CntW'(1);
    for (int i = ssnr_pkg::NumDigits - 1; i >= 1; i--) begin
      if (!found && digits_q[i] != 4'd0) begin
        found = 1'b1;
        ndig  = ssnr_pkg::CntW'(i + 1);
      end
    end
  end

  assign n16   = 16'(ndig);
  assign total = n16 * {8'b0, cfg_i.digit_width} + (n16 - 16'd1) * {8'b0, cfg_i.digit_spacing};

  assign job_o.digits  = digits_q;
  assign job_o.ndig    = ndig;
  assign job_o.x_start = ({3'b0, cfg_i.screen_width} - total) >> 1;

  always_comb begin
    state_d    = state_q;
    shown_d    = shown_q;
    rem_d      = rem_q;
    digits_d   = digits_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      ssnr_pkg::FrontIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && clamped != shown_q) begin
          shown_d = clamped;
          rem_d   = ssnr_pkg::ValW'(clamped);
          cnt_d   = '0;
          state_d = ssnr_pkg::FrontDiv;
        end
      end
      ssnr_pkg::FrontDiv: begin
        digits_d[cnt_q] = digit_full[3:0];
        rem_d = quot;
        if (cnt_q == ssnr_pkg::DigIdxW'(ssnr_pkg::NumDigits - 1)) begin
          state_d = ssnr_pkg::FrontPush;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ssnr_pkg::FrontPush: begin
        push_o = 1'b1;
        if (push_ready_i) begin
          state_d = ssnr_pkg::FrontIdle;
        end
      end
      default: state_d = ssnr_pkg::FrontIdle;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/ssnr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnr_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ssnr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                push_ready_o,
  input  wire ssnr_pkg::job_t push_job_i,
  output logic                pop_valid_o,
  input  wire logic           pop_i,
  output ssnr_pkg::job_t      pop_job_o
);

  ssnr_pkg::job_t mem_q [ssnr_pkg::QueueDepth];
  logic [ssnr_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [ssnr_pkg::QCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = cnt_q != ssnr_pkg::QCntW'(ssnr_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_job_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/ssnr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssnr_back
// Takes render jobs and issues the band clear and one rectangle per lit
// segment through a registered output stage.
// ----------------------------------------------------------------------------
module ssnr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ssnr_pkg::cfg_t cfg_i,
  input  wire logic           job_valid_i,
  output logic                job_pop_o,
  input  wire ssnr_pkg::job_t job_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ssnr_pkg::rect_t     out_rect_o
);

  ssnr_pkg::back_state_e state_q, state_d;
  logic [ssnr_pkg::NumDigits-1:0][3:0] digits_q, digits_d;
  logic [ssnr_pkg::CntW-1:0] didx_q, didx_d;
  logic [15:0] dx_q, dx_d;
  logic [ssnr_pkg::NumSegs-1:0] mask_q, mask_d;
  logic out_valid_q, out_valid_d;
  ssnr_pkg::rect_t out_q, out_d;

  logic advance;
  logic [2:0] seg;
  logic [ssnr_pkg::NumSegs-1:0] mask_rest;
  logic [15:0] dy, w, h, t, half, mt, dw_t, mid_top, mid_bot, low_top, low_bot;
  ssnr_pkg::rect_t seg_rect, clear_rect;
  logic [3:0] next_digit;

  assign advance     = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rect_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssnr_pkg::BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    didx_q   <= didx_d;
    dx_q     <= dx_d;
    mask_q   <= mask_d;
    out_q    <= out_d;
  end

  always_comb begin
    seg = ssnr_pkg::SegBot;
    for (int i = ssnr_pkg::NumSegs - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        seg = 3'(i);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - 1'b1);

  assign dy      = {4'b0, cfg_i.band_top};
  assign w       = {8'b0, cfg_i.digit_width};
  assign h       = {8'b0, cfg_i.digit_height};
  assign t       = {10'b0, cfg_i.segment_thickness};
  assign half    = h >> 1;
  assign mt      = t >> 1;
  assign dw_t    = dx_q + w - t;
  assign mid_top = dy + half - mt;
  assign mid_bot = dy + half + mt - 16'd1;
  assign low_top = dy + half + mt + 16'd1;
  assign low_bot = dy + h - t - 16'd2;

  always_comb begin
    seg_rect.color = cfg_i.digit_color;
    seg_rect.last  = (didx_q == ssnr_pkg::CntW'(1)) && (mask_rest == '0);
    case (seg)
      ssnr_pkg::SegTop: begin
        seg_rect.left   = dx_q + t;
        seg_rect.top    = dy;
        seg_rect.right  = dw_t - 16'd1;
        seg_rect.bottom = dy + t - 16'd1;
      end
      ssnr_pkg::SegUpL: begin
        seg_rect.left   = dx_q;
        seg_rect.top    = dy + t + 16'd1;
        seg_rect.right  = dx_q + t - 16'd1;
        seg_rect.bottom = mid_top - 16'd2;
      end
      ssnr_pkg::SegUpR: begin
        seg_rect.left   = dw_t;
        seg_rect.top    = dy + t + 16'd1;
        seg_rect.right  = dx_q + w - 16'd1;
        seg_rect.bottom = mid_top - 16'd2;
      end
      ssnr_pkg::SegMid: begin
        seg_rect.left   = dx_q + t;
        seg_rect.top    = mid_top;
        seg_rect.right  = dw_t - 16'd1;
        seg_rect.bottom = mid_bot;
      end
      ssnr_pkg::SegLowL: begin
        seg_rect.left   = dx_q;
        seg_rect.top    = low_top;
        seg_rect.right  = dx_q + t - 16'd1;
        seg_rect.bottom = low_bot;
      end
      ssnr_pkg::SegLowR: begin
        seg_rect.left   = dw_t;
        seg_rect.top    = low_top;
        seg_rect.right  = dx_q + w - 16'd1;
        seg_rect.bottom = low_bot;
      end
      default: begin
        seg_rect.left   = dx_q + t;
        seg_rect.top    = dy + h - t;
        seg_rect.right  = dw_t - 16'd1;
        seg_rect.bottom = dy + h - 16'd1;
      end
    endcase
  end

  assign clear_rect.left   = 16'd0;
  assign clear_rect.top    = dy;
  assign clear_rect.right  = {3'b0, cfg_i.screen_width} - 16'd1;
  assign clear_rect.bottom = dy + h - 16'd1;
  assign clear_rect.color  = cfg_i.background_color;
  assign clear_rect.last   = 1'b0;

  // didx_q counts digits left; next_digit is the digit at didx_q-2, drawn after the current one
  always_comb begin
    next_digit = 4'd0;
    for (int i = 0; i < ssnr_pkg::NumDigits; i++) begin
      if (didx_q == ssnr_pkg::CntW'(i + 2)) begin
        next_digit = digits_q[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    didx_d      = didx_q;
    dx_d        = dx_q;
    mask_d      = mask_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    job_pop_o   = 1'b0;
    case (state_q)
      ssnr_pkg::BackIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          digits_d  = job_i.digits;
          didx_d    = job_i.ndig;
          dx_d      = job_i.x_start;
          state_d   = ssnr_pkg::BackClear;
        end
      end
      ssnr_pkg::BackClear: begin
        if (advance) begin
          out_d       = clear_rect;
          out_valid_d = 1'b1;
          mask_d      = ssnr_pkg::seg_of(digits_q[didx_q - 1'b1]);
          state_d     = ssnr_pkg::BackDigit;
        end
      end
      ssnr_pkg::BackDigit: begin
        if (advance) begin
          out_d       = seg_rect;
          out_valid_d = 1'b1;
          mask_d      = mask_rest;
          if (mask_rest == '0) begin
            if (didx_q == ssnr_pkg::CntW'(1)) begin
              state_d = ssnr_pkg::BackIdle;
            end else begin
              didx_d = didx_q - 1'b1;
              dx_d   = dx_q + w + {8'b0, cfg_i.digit_spacing};
              mask_d = ssnr_pkg::seg_of(next_digit);
            end
          end
        end
      end
      default: state_d = ssnr_pkg::BackIdle;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/seven_segment_number_renderer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_renderer_unit
// Turns a numeric value into fill-rectangle commands for a seven-segment
// readout: one band clear, then one rectangle per lit segment.
// ----------------------------------------------------------------------------
// A value is taken when the front end is free; it is clamped to the largest
// shown value and dropped at once if it matches the value last accepted. A
// new value passes once per decimal digit through the shared divide by ten
// unit, then its job is queued; the front takes no new value until the queue
// accepts that job. The back end issues one rectangle per cycle while the
// sink does not stall (band clear plus each lit segment, at most 22) through
// a registered output; it pops each job in its idle state before the band
// clear. The last rectangle of an update carries tlast.
module seven_segment_number_renderer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // value_in
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // rect_left, rect_top, rect_right, rect_bottom, fill_color
  output logic [79:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  ssnr_pkg::cfg_t cfg_q;
  ssnr_pkg::job_t front_job, queue_job;
  ssnr_pkg::rect_t rect;
  logic push, push_ready, job_valid, job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width      <= 13'd240;
      cfg_q.digit_width       <= 8'd50;
      cfg_q.digit_height      <= 8'd80;
      cfg_q.segment_thickness <= 6'd8;
      cfg_q.digit_spacing     <= 8'd6;
      cfg_q.band_top          <= 12'd35;
      cfg_q.background_color  <= 16'h0000;
      cfg_q.digit_color       <= 16'hF800;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ssnr_pkg::CfgScreenWidth: cfg_q.screen_width      <= cfg_wdata_i[12:0];
        ssnr_pkg::CfgDigitWidth:  cfg_q.digit_width       <= cfg_wdata_i[7:0];
        ssnr_pkg::CfgDigitHeight: cfg_q.digit_height      <= cfg_wdata_i[7:0];
        ssnr_pkg::CfgThickness:   cfg_q.segment_thickness <= cfg_wdata_i[5:0];
        ssnr_pkg::CfgSpacing:     cfg_q.digit_spacing     <= cfg_wdata_i[7:0];
        ssnr_pkg::CfgBandTop:     cfg_q.band_top          <= cfg_wdata_i[11:0];
        ssnr_pkg::CfgBgColor:     cfg_q.background_color  <= cfg_wdata_i;
        ssnr_pkg::CfgDigitColor:  cfg_q.digit_color       <= cfg_wdata_i;
        default:                  cfg_q <= cfg_q;
      endcase
    end
  end

  ssnr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_value_i   (s_axis_tdata_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (front_job)
  );

  ssnr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (job_valid),
    .pop_i        (job_pop),
    .pop_job_o    (queue_job)
  );

  ssnr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (queue_job),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rect_o  (rect)
  );

  assign m_axis_tdata_o = {rect.color, rect.bottom, rect.right, rect.top, rect.left};
  assign m_axis_tlast_o = rect.last;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the seven-segment number renderer. Values go in on the slave stream.
// Every rectangle command on the master stream is compared with the output of
// a predictor that clamps the value, skips repeats and lays out the band clear
// and the lit segments. Several screen layouts are used: the reset one, the
// extremes, raw register noise and random ones. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb;
  import ssnr_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam logic [6:0] SegMap [10] = '{
    7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // value_in
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // rect_left, rect_top, rect_right, rect_bottom, fill_color
  logic [79:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  cfg_t        layout;
  logic [15:0] drawn_value;
  logic [15:0] last_sent;
  rect_t       pending_rects[$];
  int          idle_pct;
  int          stall_left;
  int          mismatch_count;
  int          cycle_count;

  seven_segment_number_renderer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL seven_segment_number_renderer_unit");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Clamp, skip a repeat, then queue the band clear and every lit segment.
  task automatic predict_rects(input logic [15:0] value);
    logic [15:0] v;
    logic [15:0] sw, w, h, t, s, dy, half, mt, total, diff, xs, dx;
    logic [15:0] l, tp, r, b;
    logic [6:0]  segs;
    int unsigned dig[NumDigits];
    int unsigned rem, n;
    rect_t       upd[$];
    v = (value > MaxValue) ? 16'(MaxValue) : value;
    if (v == drawn_value) return;
    drawn_value = v;
    rem = v;
    for (int i = 0; i < NumDigits; i++) begin
      dig[i] = rem % 10;
      rem = rem / 10;
    end
    n = 1;
    for (int i = 2; i <= NumDigits; i++) begin
      if (dig[i-1] != 0) n = i;
    end
    sw = 16'(layout.screen_width);
    w = 16'(layout.digit_width);
    h = 16'(layout.digit_height);
    t = 16'(layout.segment_thickness);
    s = 16'(layout.digit_spacing);
    dy = 16'(layout.band_top);
    half = h >> 1;
    mt = t >> 1;
    total = 16'(n * w + (n - 1) * s);
    diff = sw - total;
    xs = diff >> 1;
    upd.push_back('{left: 16'd0, top: dy, right: 16'(sw - 1), bottom: 16'(dy + h - 1),
                    color: layout.background_color, last: 1'b0});
    for (int i = 0; i < n; i++) begin
      dx = 16'(xs + i * (w + s));
      segs = SegMap[dig[n-1-i]];
      for (int k = 0; k < NumSegs; k++) begin
        if (segs[k]) begin
          case (3'(k))
            SegTop: begin
              l = dx + t; tp = dy; r = 16'(dx + w - t - 1); b = 16'(dy + t - 1);
            end
            SegUpL: begin
              l = dx; tp = 16'(dy + t + 1); r = 16'(dx + t - 1); b = 16'(dy + half - mt - 2);
            end
            SegUpR: begin
              l = dx + w - t; tp = 16'(dy + t + 1); r = 16'(dx + w - 1);
              b = 16'(dy + half - mt - 2);
            end
            SegMid: begin
              l = dx + t; tp = dy + half - mt; r = 16'(dx + w - t - 1);
              b = 16'(dy + half + mt - 1);
            end
            SegLowL: begin
              l = dx; tp = 16'(dy + half + mt + 1); r = 16'(dx + t - 1);
              b = 16'(dy + h - t - 2);
            end
            SegLowR: begin
              l = dx + w - t; tp = 16'(dy + half + mt + 1); r = 16'(dx + w - 1);
              b = 16'(dy + h - t - 2);
            end
            default: begin
              l = dx + t; tp = dy + h - t; r = 16'(dx + w - t - 1); b = 16'(dy + h - 1);
            end
          endcase
          upd.push_back('{left: l, top: tp, right: r, bottom: b,
                          color: layout.digit_color, last: 1'b0});
        end
      end
    end
    upd[upd.size()-1].last = 1'b1;
    foreach (upd[i]) pending_rects.push_back(upd[i]);
  endtask

  always @(posedge clk_i) begin
    rect_t got, exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{left: m_axis_tdata_o[15:0], top: m_axis_tdata_o[31:16],
              right: m_axis_tdata_o[47:32], bottom: m_axis_tdata_o[63:48],
              color: m_axis_tdata_o[79:64], last: m_axis_tlast_o};
      if (pending_rects.size() == 0) begin
        report_mismatch($sformatf("unexpected rect %h last %b", m_axis_tdata_o,
                                  m_axis_tlast_o));
      end else begin
        exp_r = pending_rects.pop_front();
        if (got.left !== exp_r.left)
          report_mismatch($sformatf("rect_left %h, want %h", got.left, exp_r.left));
        if (got.top !== exp_r.top)
          report_mismatch($sformatf("rect_top %h, want %h", got.top, exp_r.top));
        if (got.right !== exp_r.right)
          report_mismatch($sformatf("rect_right %h, want %h", got.right, exp_r.right));
        if (got.bottom !== exp_r.bottom)
          report_mismatch($sformatf("rect_bottom %h, want %h", got.bottom, exp_r.bottom));
        if (got.color !== exp_r.color)
          report_mismatch($sformatf("fill_color %h, want %h", got.color, exp_r.color));
        if (got.last !== exp_r.last)
          report_mismatch($sformatf("last_rect %b, want %b", got.last, exp_r.last));
      end
    end
  end

  // Hold tready low in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(99) < idle_pct) begin
      stall_left <= $urandom_range(14);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_value(input logic [15:0] value);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 15) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    last_sent = value;
    predict_rects(value);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgScreenWidth: layout.screen_width = data[12:0];
      CfgDigitWidth:  layout.digit_width = data[7:0];
      CfgDigitHeight: layout.digit_height = data[7:0];
      CfgThickness:   layout.segment_thickness = data[5:0];
      CfgSpacing:     layout.digit_spacing = data[7:0];
      CfgBandTop:     layout.band_top = data[11:0];
      CfgBgColor:     layout.background_color = data;
      default:        layout.digit_color = data;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_layout(input cfg_t l);
    wait_idle();
    write_reg(CfgScreenWidth, 16'(l.screen_width));
    write_reg(CfgDigitWidth, 16'(l.digit_width));
    write_reg(CfgDigitHeight, 16'(l.digit_height));
    write_reg(CfgThickness, 16'(l.segment_thickness));
    write_reg(CfgSpacing, 16'(l.digit_spacing));
    write_reg(CfgBandTop, 16'(l.band_top));
    write_reg(CfgBgColor, l.background_color);
    write_reg(CfgDigitColor, l.digit_color);
  endtask

  function automatic logic [15:0] next_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return last_sent;
    if (r < 25) return 16'($urandom());
    if (r < 40) return 16'($urandom_range(9));
    if (r < 55) return 16'($urandom_range(10, 99));
    return 16'($urandom_range(999));
  endfunction

  task automatic test_power_on_layout();
    logic [15:0] vals[$] = '{0, 0, 1, 9, 10, 11, 99, 100, 101, 999, 1000, 65535,
                             500, 65535, 42, 8, 88, 888, 7, 123, 456};
    idle_pct = 0;
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_extreme_layouts();
    cfg_t lays[3];
    logic [15:0] vals[$] = '{888, 0, 100, 65535, 1};
    lays[0] = '{screen_width: 13'd16, digit_width: 8'd8, digit_height: 8'd8,
                segment_thickness: 6'd2, digit_spacing: 8'd0, band_top: 12'd0,
                background_color: 16'h0000, digit_color: 16'h0000};
    lays[1] = '{screen_width: 13'd4096, digit_width: 8'd255, digit_height: 8'd255,
                segment_thickness: 6'd63, digit_spacing: 8'd255, band_top: 12'd4095,
                background_color: 16'hFFFF, digit_color: 16'hFFFF};
    // group wider than the screen
    lays[2] = '{screen_width: 13'd16, digit_width: 8'd255, digit_height: 8'd40,
                segment_thickness: 6'd5, digit_spacing: 8'd255, band_top: 12'd100,
                background_color: 16'h1234, digit_color: 16'hABCD};
    idle_pct = 40;
    foreach (lays[j]) begin
      set_layout(lays[j]);
      foreach (vals[i]) send_value(vals[i]);
    end
  endtask

  task automatic test_register_noise();
    idle_pct = 20;
    repeat (2) begin
      wait_idle();
      for (int k = 0; k < 8; k++) write_reg(cfg_idx_e'(k), 16'($urandom()));
      repeat (6) send_value(next_value());
    end
  endtask

  task automatic test_random_updates();
    int pcts[5] = '{30, 60, 10, 50, 0};
    cfg_t l;
    foreach (pcts[p]) begin
      l = '{screen_width: 13'($urandom_range(16, 4096)),
            digit_width: 8'($urandom_range(8, 255)),
            digit_height: 8'($urandom_range(8, 255)),
            segment_thickness: 6'($urandom_range(2, 63)),
            digit_spacing: 8'($urandom_range(255)),
            band_top: 12'($urandom_range(4095)),
            background_color: 16'($urandom()),
            digit_color: 16'($urandom())};
      if (p == 0) l = '{screen_width: 13'd240, digit_width: 8'd50, digit_height: 8'd80,
                        segment_thickness: 6'd8, digit_spacing: 8'd6, band_top: 12'd35,
                        background_color: 16'h0000, digit_color: 16'hF800};
      set_layout(l);
      idle_pct = pcts[p];
      repeat (52) send_value(next_value());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CfgScreenWidth;
    cfg_wdata_i = 16'h0000;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = 16'h0000;
    m_axis_tready_i = 1'b1;
    stall_left = 0;
    idle_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    drawn_value = 16'hFFFF;
    last_sent = 16'h0000;
    layout = '{screen_width: 13'd240, digit_width: 8'd50, digit_height: 8'd80,
               segment_thickness: 6'd8, digit_spacing: 8'd6, band_top: 12'd35,
               background_color: 16'h0000, digit_color: 16'hF800};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_power_on_layout();
    test_extreme_layouts();
    test_register_noise();
    test_random_updates();
    wait_idle();
    repeat (24) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS seven_segment_number_renderer_unit");
    end else begin
      $display("FAIL seven_segment_number_renderer_unit");
    end
    $finish;
  end

endmodule
